### hw/rtl/egbm_pkg.sv
// ============================================================================
// Edge grid block mapper package
// Shared widths, register indexes and reset values for the grid mapper.
// ============================================================================
`default_nettype none

package egbm_pkg;

    // Default width of a vertex id.
    localparam int unsigned VERTEX_BITS_DEF = 48;

    // Width of the grid width register, of block coordinates and of offsets.
    localparam int unsigned GRID_BITS = 32;

    typedef logic [GRID_BITS-1:0] t_word;

    // Configuration port.
    localparam int unsigned CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOWER_TRI  = 1'b1;

    // Reset value of the grid width register.
    localparam t_word GRID_WIDTH_RST = 32'd16777216;

endpackage

`default_nettype wire

### hw/rtl/egbm_div_step.sv
// ============================================================================
// Edge grid block mapper divider step
// One registered restoring division step for the source and destination
// lanes: each stage settles one quotient bit of each vertex id.
// ============================================================================
`default_nettype none

module egbm_div_step
    import egbm_pkg::*;
#(
    parameter int unsigned VERTEX_BITS = VERTEX_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_en,
    input  wire                                   i_valid,
    input  wire t_word                            i_divisor,
    input  wire [1:0][VERTEX_BITS-1:0]            i_dvd,
    input  wire t_word [1:0]                      i_rem,
    input  wire [1:0][((VERTEX_BITS < GRID_BITS) ? VERTEX_BITS : GRID_BITS)-1:0] i_quo,
    output logic                                  o_valid,
    output logic [1:0][VERTEX_BITS-1:0]           o_dvd,
    output t_word [1:0]                           o_rem,
    output logic [1:0][((VERTEX_BITS < GRID_BITS) ? VERTEX_BITS : GRID_BITS)-1:0] o_quo
);

    // Only the low quotient bits are kept.
    localparam int unsigned QW = (VERTEX_BITS < GRID_BITS) ? VERTEX_BITS : GRID_BITS;

    logic                        r_valid;
    logic [1:0][VERTEX_BITS-1:0] r_dvd;
    t_word [1:0]                 r_rem;
    logic [1:0][QW-1:0]          r_quo;

    logic [1:0][VERTEX_BITS-1:0] n_dvd;
    t_word [1:0]                 n_rem;
    logic [1:0][QW-1:0]          n_quo;

    // Trial subtract of the divisor from the shifted partial remainder.
    // With a zero divisor every bit is a one and the remainder becomes the
    // low bits of the dividend, which is the required answer.
    always_comb begin
        logic [GRID_BITS:0] trial;
        logic               ge;
        for (int l = 0; l < 2; l++) begin
            trial    = {i_rem[l], i_dvd[l][VERTEX_BITS-1]};
            ge       = (trial >= {1'b0, i_divisor});
            n_rem[l] = ge ? t_word'(trial - {1'b0, i_divisor}) : trial[GRID_BITS-1:0];
            n_quo[l] = {i_quo[l][QW-2:0], ge};
            n_dvd[l] = {i_dvd[l][VERTEX_BITS-2:0], 1'b0};
        end
    end

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_dvd   = r_dvd;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule

`default_nettype wire

### hw/rtl/edge_grid_block_mapper.sv
// An accepted edge passes the front stage, the divider stages and the output register before o_valid.
// Throughput: one edge per cycle while the skid entry is free; the divider settles one quotient bit per
// pipeline stage, so each stage holds its own edge.
// A two-entry output buffer keeps o_ready high while one result waits.
// Reset (synchronous, active low) empties the pipeline and sets grid_width to
// 16777216 and lower_triangular to 0.
// ============================================================================
// Edge grid block mapper
// Maps each graph edge to a grid block and the offsets inside that block,
// optionally folding edges to the lower triangle and dropping self-loops.
// ============================================================================
`default_nettype none

module edge_grid_block_mapper
    import egbm_pkg::*;
#(
    parameter int unsigned VERTEX_BITS = VERTEX_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // Configuration channel
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire [CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire [GRID_BITS-1:0]      i_cfg_data,
    // Edge channel
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire [VERTEX_BITS-1:0]    i_source_vertex,
    input  wire [VERTEX_BITS-1:0]    i_dest_vertex,
    // Result channel
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic [GRID_BITS-1:0]     o_row_block,
    output logic [GRID_BITS-1:0]     o_col_block,
    output logic [GRID_BITS-1:0]     o_row_offset,
    output logic [GRID_BITS-1:0]     o_col_offset
);

    localparam int unsigned QW = (VERTEX_BITS < GRID_BITS) ? VERTEX_BITS : GRID_BITS;

    // Configuration registers.
    t_word r_grid_width;
    logic  r_lower_tri;

    // Front stage: fold and self-loop filter.
    logic                        r_s0_valid;
    logic [1:0][VERTEX_BITS-1:0] r_s0_dvd;
    logic                        n_s0_valid;
    logic [1:0][VERTEX_BITS-1:0] n_s0_dvd;
    logic                        w_swap;

    // Divider chain.
    logic                        w_valid [VERTEX_BITS+1];
    logic [1:0][VERTEX_BITS-1:0] w_dvd   [VERTEX_BITS+1];
    t_word [1:0]                 w_rem   [VERTEX_BITS+1];
    logic [1:0][QW-1:0]          w_quo   [VERTEX_BITS+1];

    // Output register and skid entry.
    logic        r_out_valid;
    t_word [1:0] r_out_quo;
    t_word [1:0] r_out_rem;
    logic        r_skd_valid;
    t_word [1:0] r_skd_quo;
    t_word [1:0] r_skd_rem;
    t_word [1:0] w_last_quo;
    logic        w_zero_width;
    logic        w_en;
    logic        w_out_load;

    // The pipeline moves whenever the skid entry is free.
    assign w_en        = !r_skd_valid;
    assign o_ready     = w_en;
    assign o_cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= GRID_WIDTH_RST;
            r_lower_tri  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH: r_grid_width <= i_cfg_data;
                CFG_LOWER_TRI:  r_lower_tri  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Swap ends in lower-triangular mode; drop self-loops.
    always_comb begin
        w_swap      = r_lower_tri && (i_source_vertex < i_dest_vertex);
        n_s0_valid  = i_valid && (i_source_vertex != i_dest_vertex);
        n_s0_dvd[0] = w_swap ? i_dest_vertex : i_source_vertex;
        n_s0_dvd[1] = w_swap ? i_source_vertex : i_dest_vertex;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= n_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_dvd <= n_s0_dvd;
        end
    end

    // Head of the divider chain: empty remainder and quotient.
    assign w_valid[0] = r_s0_valid;
    assign w_dvd[0]   = r_s0_dvd;
    assign w_rem[0]   = '0;
    assign w_quo[0]   = '0;

    // One quotient bit per stage.
    for (genvar k = 0; k < VERTEX_BITS; k++) begin : g_div
        egbm_div_step #(
            .VERTEX_BITS (VERTEX_BITS)
        ) u_step (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_valid   (w_valid[k]),
            .i_divisor (r_grid_width),
            .i_dvd     (w_dvd[k]),
            .i_rem     (w_rem[k]),
            .i_quo     (w_quo[k]),
            .o_valid   (w_valid[k+1]),
            .o_dvd     (w_dvd[k+1]),
            .o_rem     (w_rem[k+1]),
            .o_quo     (w_quo[k+1])
        );
    end

    // A zero width gives an all-ones block even when the ids are narrower
    // than a block coordinate.
    assign w_zero_width  = (r_grid_width == '0);
    assign w_last_quo[0] = w_zero_width ? '1 : t_word'(w_quo[VERTEX_BITS][0]);
    assign w_last_quo[1] = w_zero_width ? '1 : t_word'(w_quo[VERTEX_BITS][1]);

    // The output register reloads when it is empty or its request is taken.
    assign w_out_load = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_skd_valid || w_valid[VERTEX_BITS];
            r_skd_valid <= 1'b0;
        end else if (w_en && w_valid[VERTEX_BITS]) begin
            r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_quo <= r_skd_valid ? r_skd_quo : w_last_quo;
            r_out_rem <= r_skd_valid ? r_skd_rem : w_rem[VERTEX_BITS];
        end
        if (!w_out_load && w_en) begin
            r_skd_quo <= w_last_quo;
            r_skd_rem <= w_rem[VERTEX_BITS];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_row_block  = r_out_quo[0];
    assign o_col_block  = r_out_quo[1];
    assign o_row_offset = r_out_rem[0];
    assign o_col_offset = r_out_rem[1];

`ifndef SYNTHESIS
    // The skid entry is only ever filled behind a held output request.
    a_skd_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid entry holds a request while the output is empty");

    a_skd_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skd_valid) |-> $past(r_out_valid && !i_ready))
        else $error("skid entry filled while the output could move");

    // A self-loop never enters the divider.
    a_self_loop_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_source_vertex == i_dest_vertex)) |=> !r_s0_valid)
        else $error("self-loop edge entered the divider");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("output not empty after reset");
`endif

endmodule

`default_nettype wire

### tb/edge_grid_block_mapper_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Edge grid block mapper testbench
// Streams graph edges through the mapper under several grid widths, with
// and without lower-triangular folding. Every accepted edge request is fed to
// an in-bench model of the grid split. Each result request is checked field by
// field against the oldest outstanding cell. Both channels idle at random.
// ============================================================================

import egbm_pkg::*;

typedef logic [VERTEX_BITS_DEF-1:0] vertex_t;

typedef struct packed {
    t_word row_block;
    t_word col_block;
    t_word row_offset;
    t_word col_offset;
} grid_cell_t;

// Mirrors the mapper's registers and keeps the cells still owed by the block.
class grid_cell_ledger;
    t_word       grid_width;
    bit          lower_tri;
    grid_cell_t  pending[$];
    int unsigned failures;

    function new();
        grid_width = GRID_WIDTH_RST;
        lower_tri  = 1'b0;
        failures   = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_BITS-1:0] idx, input t_word data);
        if (idx == CFG_GRID_WIDTH) begin
            grid_width = data;
        end else if (idx == CFG_LOWER_TRI) begin
            lower_tri = data[0];
        end
    endfunction

    // A zero width behaves as a divider by zero: all-ones block, raw low bits.
    function void split_vertex(input longint unsigned v, output t_word blk,
                               output t_word off);
        longint unsigned w;
        w = 64'(grid_width);
        if (w == 0) begin
            blk = '1;
            off = t_word'(v);
        end else begin
            blk = t_word'(v / w);
            off = t_word'(v % w);
        end
    endfunction

    // Works out the cell for an accepted edge; self-loops owe nothing.
    function void note_edge(input vertex_t src, input vertex_t dst);
        longint unsigned s;
        longint unsigned d;
        longint unsigned t;
        grid_cell_t      owed;
        s = 64'(src);
        d = 64'(dst);
        if (lower_tri && s < d) begin
            t = s;
            s = d;
            d = t;
        end else if (s == d) begin
            return;
        end
        split_vertex(s, owed.row_block, owed.row_offset);
        split_vertex(d, owed.col_block, owed.col_offset);
        pending.insert(pending.size(), owed);
    endfunction

    function void check_cell(input grid_cell_t got);
        grid_cell_t want;
        if (pending.size() == 0) begin
            failures++;
            if (failures <= 10) begin
                $display("ERROR: unexpected cell rb=%h cb=%h ro=%h co=%h",
                         got.row_block, got.col_block, got.row_offset, got.col_offset);
            end
            return;
        end
        want = pending.pop_front();
        if (got.row_block !== want.row_block || got.col_block !== want.col_block ||
            got.row_offset !== want.row_offset || got.col_offset !== want.col_offset) begin
            failures++;
            if (failures <= 10) begin
                $display({"ERROR: cell mismatch exp rb=%h cb=%h ro=%h co=%h",
                          " got rb=%h cb=%h ro=%h co=%h"},
                         want.row_block, want.col_block, want.row_offset, want.col_offset,
                         got.row_block, got.col_block, got.row_offset, got.col_offset);
            end
        end
    endfunction
endclass

module edge_grid_block_mapper_test;

    localparam int unsigned VB           = VERTEX_BITS_DEF;
    localparam int unsigned SETTLE_TICKS = VB + 12;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam vertex_t     VERTEX_MAX   = '1;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = CFG_GRID_WIDTH;
    t_word                   i_cfg_data = '0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    vertex_t                 i_source_vertex = '0;
    vertex_t                 i_dest_vertex = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    t_word                   o_row_block;
    t_word                   o_col_block;
    t_word                   o_row_offset;
    t_word                   o_col_offset;

    grid_cell_ledger ledger;
    int unsigned     edge_gap_max = 5;
    int unsigned     cell_gap_max = 5;
    int unsigned     cycle_count = 0;

    edge_grid_block_mapper #(.VERTEX_BITS(VB)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_source_vertex(i_source_vertex),
        .i_dest_vertex  (i_dest_vertex),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_row_block    (o_row_block),
        .o_col_block    (o_col_block),
        .o_row_offset   (o_row_offset),
        .o_col_offset   (o_col_offset)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog: a stuck handshake or a lost cell ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before each request.
    initial begin
        int unsigned gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, cell_gap_max);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            ledger.check_cell({o_row_block, o_col_block, o_row_offset, o_col_offset});
        end
    end

    // Valid is only lowered when a gap follows, so back-to-back requests keep it high.
    task automatic send_edge(input vertex_t s, input vertex_t d);
        int unsigned gap;
        gap = $urandom_range(0, edge_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_source_vertex <= s;
        i_dest_vertex   <= d;
        do @(posedge i_clk); while (!o_ready);
        ledger.note_edge(s, d);
    endtask

    // Stop the edge stream and let the pipeline empty, dropped edges included.
    task automatic settle_edges();
        i_valid <= 1'b0;
        while (ledger.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input t_word data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        ledger.set_reg(idx, data);
    endtask

    // The folding flag only looks at bit 0, so the upper bits carry noise.
    task automatic program_grid(input t_word width, input bit lt);
        t_word flag_word;
        flag_word    = $urandom();
        flag_word[0] = lt;
        write_reg(CFG_GRID_WIDTH, width);
        write_reg(CFG_LOWER_TRI, flag_word);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic vertex_t wide_random();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        if ($urandom_range(0, 1) == 1) begin
            r = r >> $urandom_range(0, VB - 1);
        end
        return r[VB-1:0];
    endfunction

    function automatic vertex_t extreme_vertex();
        case ($urandom_range(0, 2))
            0: return '0;
            1: return VERTEX_MAX;
            default: return wide_random();
        endcase
    endfunction

    // Lands on the first or last vertex of some block.
    function automatic vertex_t boundary_vertex(input longint unsigned w);
        longint unsigned k;
        k = 64'($urandom());
        if ($urandom_range(0, 1) == 1) begin
            return vertex_t'(k * w);
        end
        return vertex_t'(k * w + w - 1);
    endfunction

    task automatic make_pair(output vertex_t s, output vertex_t d);
        int unsigned     kind;
        longint unsigned w;
        kind = $urandom_range(0, 19);
        w    = 64'(ledger.grid_width);
        s    = wide_random();
        d    = wide_random();
        if (kind == 8 || kind == 9) begin
            d = s;
        end else if (kind == 10 || kind == 11) begin
            s = vertex_t'($urandom_range(0, 1023));
            d = vertex_t'($urandom_range(0, 1023));
        end else if (kind == 12 || kind == 13) begin
            d = ($urandom_range(0, 1) == 1) ? s + 1'b1 : s - 1'b1;
        end else if (kind == 14 || kind == 15) begin
            s = extreme_vertex();
            d = extreme_vertex();
        end else if (kind >= 16) begin
            s = boundary_vertex(w);
            d = boundary_vertex(w);
        end
    endtask

    initial begin
        t_word   width;
        vertex_t s;
        vertex_t d;
        ledger = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: block-aligned edges, extremes and self-loops.
        send_edge(48'd0, 48'd1);
        send_edge(48'd1, 48'd0);
        send_edge(48'd5, 48'd5);
        send_edge(VERTEX_MAX, VERTEX_MAX - 1'b1);
        send_edge(VERTEX_MAX, 48'd0);
        send_edge(48'd0, 48'd0);
        send_edge(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
        send_edge(48'd50331655, 48'd16777215);
        settle_edges();

        // Unit width with folding: quotients wider than 32 bits are cut.
        program_grid(32'd1, 1'b1);
        send_edge(48'd3, 48'd7);
        send_edge(48'd7, 48'd3);
        send_edge(48'd9, 48'd9);
        send_edge(48'd0, VERTEX_MAX);
        send_edge(VERTEX_MAX, VERTEX_MAX);
        settle_edges();

        // Zero width: all-ones blocks and the raw low bits as offsets.
        program_grid(32'd0, 1'b0);
        send_edge(VERTEX_MAX, 48'd1);
        send_edge(48'h1234_5678_9ABC, 48'hFEDC_BA98_7654);
        send_edge(48'd4, 48'd4);
        settle_edges();

        // Widest grid with folding.
        program_grid(32'hFFFF_FFFF, 1'b1);
        send_edge(VERTEX_MAX, VERTEX_MAX - 1'b1);
        send_edge(48'hFFFF_FFFE, 48'hFFFF_FFFF);
        send_edge(48'hFFFF_FFFF, 48'hFFFF_FFFF);
        settle_edges();

        // Random phases, each under its own grid and idling pattern.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: width = 32'd1;
                1: width = 32'hFFFF_FFFF;
                2: width = 32'd0;
                3: width = $urandom_range(1, 1000);
                4: width = 32'd1 << $urandom_range(0, 31);
                5: width = $urandom();
                6: width = GRID_WIDTH_RST;
                default: width = $urandom() >> $urandom_range(0, 31);
            endcase
            program_grid(width, p[0]);
            edge_gap_max = p[1] ? 0 : 5;
            cell_gap_max = p[2] ? 0 : 5;
            repeat (194) begin
                make_pair(s, d);
                send_edge(s, d);
            end
            settle_edges();
        end

        if (ledger.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
